// ===== rtl/core/csk_pkg.sv =====
package csk_pkg;

   // sizes
   localparam int STACK_DEPTH = 64;
   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int TOP_W = $clog2(STACK_DEPTH + 1);
   localparam int CNT_W = TOP_W;

   // operation codes
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_TOP   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam logic signed [7:0] OCC_ABSENT = -8'sd1;
   localparam logic signed [7:0] OCC_NONE   = 8'sd0;

   // input item
   typedef struct packed {
      op_type      kind;
      logic [63:0] key;
   } req_type;

   // result item
   typedef struct packed {
      status_type        status;
      logic [63:0]       key_out;
      logic signed [7:0] occurrences;
      logic [6:0]        depth;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic stk_rd;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   scan_last;
   } sts_type;

   // count clipped to the signed 8-bit result range
   function automatic logic signed [7:0] occ_sat(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      if (wide > 32'd127) begin
         return 8'sd127;
      end
      return signed'(wide[7:0]);
   endfunction

   // stack depth masked to the 7-bit result field
   function automatic logic [6:0] depth_of(input logic [TOP_W-1:0] top);
      logic [31:0] wide;
      wide = 32'(top);
      return wide[6:0];
   endfunction

endpackage

// ===== rtl/core/call_stack_with_key_counts_unit.sv =====
// from accept to result strobe: push and query scan the count table, drain, finish;
// pop reads the stack, then scans like push; top reads the stack and finishes; push on
// full or pop/top on empty goes straight to finish; a new item is taken in the cycle the
// previous result is strobed; the count table scan reads one entry per cycle through
// its single read port; reset (synchronous) empties the stack and clears all table
// valid bits; results are strobed for one cycle; the receiver cannot stall
module call_stack_with_key_counts_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  csk_pkg::req_type  req_item,
   output logic              rsp_valid,
   output csk_pkg::rsp_type  rsp_item
);

   csk_pkg::cmd_type cmd;
   csk_pkg::sts_type sts;

   // sequencer
   csk_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.kind),
      .sts      (sts),
      .busy     (busy),
      .cmd      (cmd)
   );

   // stack, count table and result register
   csk_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   // an accepted item holds off the next one
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   // a result follows exactly the finishing cycle
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.finish))
      else $error("result strobe without a finished item");

   // an empty status always reports zero depth
   a_empty_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == csk_pkg::ST_EMPTY)) |-> (rsp_item.depth == 7'd0))
      else $error("empty status with nonzero depth");

   // failed operations return a zero key
   a_err_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != csk_pkg::ST_OK)) |-> (rsp_item.key_out == 64'd0))
      else $error("nonzero key on a failed operation");

endmodule

// ===== rtl/core/csk_ctrl.sv =====
module csk_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  csk_pkg::op_type   req_kind,
   input  csk_pkg::sts_type  sts,
   output logic              busy,
   output csk_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_STK_RD = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DRAIN  = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_kind) inside
                  csk_pkg::OP_PUSH:  state_in = sts.full ? S_FINISH : S_SCAN;
                  csk_pkg::OP_POP,
                  csk_pkg::OP_TOP:   state_in = sts.empty ? S_FINISH : S_STK_RD;
                  csk_pkg::OP_QUERY: state_in = S_SCAN;
                  default:           state_in = S_IDLE;
               endcase
            end
         end
         S_STK_RD: begin
            state_in = (sts.op == csk_pkg::OP_POP) ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN:  state_in = S_FINISH;
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // commands
   assign busy       = (state_ff != S_IDLE);
   assign cmd.load   = (state_ff == S_IDLE) && start;
   assign cmd.stk_rd = (state_ff == S_STK_RD);
   assign cmd.scan   = (state_ff == S_SCAN);
   assign cmd.finish = (state_ff == S_FINISH);

endmodule

// ===== rtl/core/csk_datapath.sv =====
module csk_datapath (
   input  logic              clock,
   input  logic              reset,
   input  csk_pkg::req_type  req_item,
   input  csk_pkg::cmd_type  cmd,
   output csk_pkg::sts_type  sts,
   output logic              rsp_valid,
   output csk_pkg::rsp_type  rsp_item
);

   localparam int IDX_W = csk_pkg::IDX_W;
   localparam int TOP_W = csk_pkg::TOP_W;
   localparam int CNT_W = csk_pkg::CNT_W;
   localparam int DEPTH = csk_pkg::STACK_DEPTH;

   csk_pkg::req_type req_ff;
   logic [TOP_W-1:0] top_ff;
   logic [TOP_W-1:0] top_in;
   logic [TOP_W-1:0] top_m1;

   logic [63:0]      stack_keys_ff [DEPTH];
   logic [63:0]      stk_rd_ff;

   logic [63:0]      tbl_keys_ff [DEPTH];
   logic [CNT_W-1:0] tbl_cnts_ff [DEPTH];
   logic [DEPTH-1:0] tbl_valid_ff;

   logic [IDX_W-1:0] scan_addr_ff;
   logic             cmp_vld_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic [63:0]      key_rd_ff;
   logic [CNT_W-1:0] cnt_rd_ff;

   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [CNT_W-1:0] hit_cnt_ff;
   logic             free_ff;
   logic [IDX_W-1:0] free_idx_ff;

   logic [63:0]      skey;
   logic             full;
   logic             empty;
   logic             push_ok;
   logic             pop_ok;
   logic             cnt_we;
   logic [IDX_W-1:0] cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;
   logic             hit_now;
   logic             free_now;

   csk_pkg::rsp_type rsp_in;
   csk_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   // stack pointer status
   assign full   = (top_ff == TOP_W'(DEPTH));
   assign empty  = (top_ff == '0);
   assign top_m1 = top_ff - TOP_W'(1);

   assign sts.op        = req_ff.kind;
   assign sts.full      = full;
   assign sts.empty     = empty;
   assign sts.scan_last = cmd.scan && (scan_addr_ff == IDX_W'(DEPTH - 1));

   // search key: the popped key or the key of the item
   assign skey = (req_ff.kind == csk_pkg::OP_POP) ? stk_rd_ff : req_ff.key;

   assign push_ok = cmd.finish && (req_ff.kind == csk_pkg::OP_PUSH) && !full;
   assign pop_ok  = cmd.finish && (req_ff.kind == csk_pkg::OP_POP) && !empty;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (push_ok) begin
         stack_keys_ff[top_ff[IDX_W-1:0]] <= req_ff.key;
      end
      if (cmd.stk_rd) begin
         stk_rd_ff <= stack_keys_ff[top_m1[IDX_W-1:0]];
      end
   end

   // stack depth
   always_comb begin
      top_in = top_ff;
      if (push_ok) begin
         top_in = top_ff + TOP_W'(1);
      end else if (pop_ok) begin
         top_in = top_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= '0;
      end else begin
         top_ff <= top_in;
      end
   end

   // count table write port
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = hit_idx_ff;
      cnt_wdata = hit_cnt_ff;
      if (push_ok) begin
         if (hit_ff) begin
            cnt_we    = 1'b1;
            cnt_wdata = hit_cnt_ff + CNT_W'(1);
         end else if (free_ff) begin
            cnt_we    = 1'b1;
            cnt_waddr = free_idx_ff;
            cnt_wdata = CNT_W'(1);
         end
      end else if (pop_ok && hit_ff && (hit_cnt_ff > CNT_W'(1))) begin
         cnt_we    = 1'b1;
         cnt_wdata = hit_cnt_ff - CNT_W'(1);
      end
   end

   // count table memories, read one entry per scan cycle
   always_ff @(posedge clock) begin
      if (push_ok && !hit_ff && free_ff) begin
         tbl_keys_ff[free_idx_ff] <= req_ff.key;
      end
      if (cmd.scan) begin
         key_rd_ff <= tbl_keys_ff[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         tbl_cnts_ff[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.scan) begin
         cnt_rd_ff <= tbl_cnts_ff[scan_addr_ff];
      end
   end

   // entry valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (push_ok && !hit_ff && free_ff) begin
         tbl_valid_ff[free_idx_ff] <= 1'b1;
      end else if (pop_ok && hit_ff && (hit_cnt_ff <= CNT_W'(1))) begin
         tbl_valid_ff[hit_idx_ff] <= 1'b0;
      end
   end

   // scan address and compare stage
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_vld_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.scan;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
      cmp_idx_ff <= scan_addr_ff;
   end

   assign hit_now  = cmp_vld_ff && tbl_valid_ff[cmp_idx_ff] && (key_rd_ff == skey);
   assign free_now = cmp_vld_ff && !tbl_valid_ff[cmp_idx_ff];

   // match and first free entry found by the scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else begin
         if (hit_now && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= cmp_idx_ff;
            hit_cnt_ff <= cnt_rd_ff;
         end
         if (free_now && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= cmp_idx_ff;
         end
      end
   end

   // result item
   always_comb begin
      rsp_in.status      = csk_pkg::ST_OK;
      rsp_in.key_out     = '0;
      rsp_in.occurrences = csk_pkg::OCC_NONE;
      rsp_in.depth       = csk_pkg::depth_of(top_in);
      case (req_ff.kind) inside
         csk_pkg::OP_PUSH: begin
            if (full) begin
               rsp_in.status = csk_pkg::ST_FULL;
            end else begin
               rsp_in.key_out = req_ff.key;
            end
         end
         csk_pkg::OP_POP, csk_pkg::OP_TOP: begin
            if (empty) begin
               rsp_in.status = csk_pkg::ST_EMPTY;
            end else begin
               rsp_in.key_out = stk_rd_ff;
            end
         end
         default: begin
            rsp_in.occurrences = hit_ff ? csk_pkg::occ_sat(hit_cnt_ff) : csk_pkg::OCC_ABSENT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
